// ===== hw/rtl/teq_pkg.sv =====
`default_nettype none

package teq_pkg;

  localparam int RING_SLOTS_DEFAULT = 16;

  localparam logic [19:0] USEC_LIMIT = 20'd999998;
  localparam logic [19:0] LEAD_USEC  = 20'd10;
  localparam logic [19:0] CLOSE_USEC = 20'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_USEC = 2'd1;
  localparam logic [1:0] STATUS_TOO_LATE = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] event_sec;
    logic [19:0] event_usec;
    logic [7:0]  handler_id;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_word_t;

  typedef struct packed {
    logic [1:0] insert_status;
    logic       fired;
    logic [7:0] fired_handler;
    logic       dropped_count;
    logic [3:0] queue_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
    logic [7:0]  hid;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PLACE,
    S_TICK_HEAD,
    S_TICK_NEXT
  } teq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/timed_event_queue_top.sv =====
`default_nettype none

// Sorted queue of timer deadlines, each a seconds and microseconds pair with a handler id.
// A word is accepted at a rising edge where start is high and busy is low. An insert word
// places a deadline in time order or rejects it with a status; a tick word carries the
// current time and removes at most one head entry (plus a close follower), firing or
// dropping it. Every accepted word gives exactly one result word, shown on out_word for
// one cycle while out_strobe is high; the receiver cannot stall it.
// The entries live in one ring memory with a registered read, so busy stays
// high while a word is worked on. A rejected insert, an insert into an empty queue and a
// tick on an empty queue end in the accepting cycle. An insert into a non-empty queue
// moves each later entry up one slot, one memory read and one memory write per step.
// A tick reads the head, then the follower too when the head fires and two are held.
// The result appears on the cycle after the last one of the word; start may be raised
// again in that same cycle.
// After reset the queue is empty and the memory content is never read before written.

module timed_event_queue_top
  import teq_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_strobe,
  output out_word_t      out_word
);

  localparam int IDX_W = $clog2(RING_SLOTS);

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    wrap_next = (i == IDX_W'(RING_SLOTS - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] i);
    wrap_prev = (i == '0) ? IDX_W'(RING_SLOTS - 1) : i - IDX_W'(1);
  endfunction

  function automatic logic [3:0] count_field(input logic [IDX_W-1:0] c);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, c};
    count_field = ext[3:0];
  endfunction

  entry_t ring_mem [RING_SLOTS];

  teq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  in_word_t         item_r, item_nxt;
  entry_t           hold_r, hold_nxt;
  entry_t           rdata_r;
  logic             out_strobe_r, out_strobe_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;

  logic   accept;
  logic   ins_bad, ins_late, ins_full, ins_empty;
  entry_t in_entry, new_entry;
  logic   shift_more, head_reached;
  logic   head_stale, head_due, two_held, follower_close;

  assign accept    = start && (state_r == S_IDLE);
  assign in_entry  = '{sec: in_word.event_sec, usec: in_word.event_usec,
                       hid: in_word.handler_id};
  assign new_entry = '{sec: item_r.event_sec, usec: item_r.event_usec,
                       hid: item_r.handler_id};

  assign ins_bad   = in_word.event_usec > USEC_LIMIT;
  assign ins_late  = (in_word.now_sec > in_word.event_sec) ||
                     ((in_word.now_sec == in_word.event_sec) &&
                      (({1'b0, in_word.now_usec} + {1'b0, LEAD_USEC}) >
                       {1'b0, in_word.event_usec}));
  assign ins_full  = cnt_r == IDX_W'(RING_SLOTS - 1);
  assign ins_empty = cnt_r == '0;
  assign two_held  = (cnt_r != '0) && (cnt_r != IDX_W'(1));

  assign shift_more   = (rdata_r.sec > new_entry.sec) ||
                        ((rdata_r.sec == new_entry.sec) && (rdata_r.usec > new_entry.usec));
  assign head_reached = wrap_prev(pos_r) == head_r;

  assign head_stale     = rdata_r.sec < item_r.now_sec;
  assign head_due       = (rdata_r.sec == item_r.now_sec) && (rdata_r.usec <= item_r.now_usec);
  assign follower_close = (rdata_r.sec == hold_r.sec) &&
                          (({1'b0, hold_r.usec} + {1'b0, CLOSE_USEC}) >= {1'b0, rdata_r.usec});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.opcode == OP_INSERT) begin
            if (!ins_bad && !ins_late && !ins_full && !ins_empty) begin
              state_nxt = S_INS_SHIFT;
            end
          end else if (!ins_empty) begin
            state_nxt = S_TICK_HEAD;
          end
        end
      end
      S_INS_SHIFT: begin
        if (shift_more) begin
          state_nxt = head_reached ? S_INS_PLACE : S_INS_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_PLACE: state_nxt = S_IDLE;
      S_TICK_HEAD: begin
        if (!head_stale && head_due && two_held) begin
          state_nxt = S_TICK_NEXT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK_NEXT: state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    hold_nxt       = hold_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = new_entry;
    mem_raddr      = wrap_prev(pos_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt       = in_word;
          out_word_nxt.queue_count = count_field(cnt_r);
          if (in_word.opcode == OP_INSERT) begin
            out_strobe_nxt = 1'b1;
            if (ins_bad) begin
              out_word_nxt.insert_status = STATUS_BAD_USEC;
            end else if (ins_late) begin
              out_word_nxt.insert_status = STATUS_TOO_LATE;
            end else if (ins_full) begin
              out_word_nxt.insert_status = STATUS_FULL;
            end else if (ins_empty) begin
              mem_we    = 1'b1;
              mem_waddr = tail_r;
              mem_wdata = in_entry;
              tail_nxt  = wrap_next(tail_r);
              cnt_nxt   = cnt_r + IDX_W'(1);
              out_word_nxt.insert_status = STATUS_OK;
              out_word_nxt.queue_count   = count_field(cnt_nxt);
            end else begin
              out_strobe_nxt = 1'b0;
              pos_nxt        = tail_r;
              mem_raddr      = wrap_prev(tail_r);
            end
          end else begin
            out_strobe_nxt = ins_empty;
            mem_raddr      = head_r;
          end
        end
      end
      S_INS_SHIFT: begin
        mem_we = 1'b1;
        if (shift_more) begin
          mem_wdata = rdata_r;
          pos_nxt   = wrap_prev(pos_r);
          mem_raddr = wrap_prev(wrap_prev(pos_r));
        end else begin
          tail_nxt       = wrap_next(tail_r);
          cnt_nxt        = cnt_r + IDX_W'(1);
          out_strobe_nxt = 1'b1;
          out_word_nxt.insert_status = STATUS_OK;
          out_word_nxt.queue_count   = count_field(cnt_nxt);
        end
      end
      S_INS_PLACE: begin
        mem_we         = 1'b1;
        tail_nxt       = wrap_next(tail_r);
        cnt_nxt        = cnt_r + IDX_W'(1);
        out_strobe_nxt = 1'b1;
        out_word_nxt.insert_status = STATUS_OK;
        out_word_nxt.queue_count   = count_field(cnt_nxt);
      end
      S_TICK_HEAD: begin
        hold_nxt  = rdata_r;
        mem_raddr = wrap_next(head_r);
        if (head_stale) begin
          head_nxt       = wrap_next(head_r);
          cnt_nxt        = cnt_r - IDX_W'(1);
          out_strobe_nxt = 1'b1;
          out_word_nxt.dropped_count = 1'b1;
          out_word_nxt.queue_count   = count_field(cnt_nxt);
        end else if (head_due && !two_held) begin
          head_nxt       = wrap_next(head_r);
          cnt_nxt        = cnt_r - IDX_W'(1);
          out_strobe_nxt = 1'b1;
          out_word_nxt.fired         = 1'b1;
          out_word_nxt.fired_handler = rdata_r.hid;
          out_word_nxt.queue_count   = count_field(cnt_nxt);
        end else if (!head_due) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt.queue_count = count_field(cnt_r);
        end
      end
      S_TICK_NEXT: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt.fired         = 1'b1;
        out_word_nxt.fired_handler = hold_r.hid;
        if (follower_close) begin
          head_nxt = wrap_next(wrap_next(head_r));
          cnt_nxt  = cnt_r - IDX_W'(1) - IDX_W'(1);
          out_word_nxt.dropped_count = 1'b1;
        end else begin
          head_nxt = wrap_next(head_r);
          cnt_nxt  = cnt_r - IDX_W'(1);
        end
        out_word_nxt.queue_count = count_field(cnt_nxt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= ring_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    hold_r     <= hold_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= RING_SLOTS - 1)
    else $error("queue holds more entries than the ring allows");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((tail_r >= head_r) ? (int'(tail_r) - int'(head_r))
                        : (int'(tail_r) + RING_SLOTS - int'(head_r))) == int'(cnt_r))
    else $error("head, tail and count disagree");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word shown while a word is still in work");

  a_fire_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.fired) |->
      ($past(state_r) == S_TICK_HEAD || $past(state_r) == S_TICK_NEXT))
    else $error("handler fired outside a tick");
`endif

endmodule

`default_nettype wire
